[rtl/utf8d_pkg.sv]
// Shared types and constants for the UTF-8 to code point decoder.
// No dependencies; imported by every module of the block.
`default_nettype none
package utf8d_pkg;

  localparam int TEXT_W  = 8;
  localparam int CP_W    = 21;
  localparam int COUNT_W = 3;

  // Lead byte class boundaries
  localparam logic [TEXT_W-1:0] LEAD2_MIN = 8'hC0;
  localparam logic [TEXT_W-1:0] LEAD3_MIN = 8'hE0;
  localparam logic [TEXT_W-1:0] LEAD4_MIN = 8'hF0;
  localparam logic [TEXT_W-1:0] BYTE_MAX  = 8'hFF;

  // Sequence length codes
  localparam logic [COUNT_W-1:0] LEN1 = 3'd1;
  localparam logic [COUNT_W-1:0] LEN2 = 3'd2;
  localparam logic [COUNT_W-1:0] LEN3 = 3'd3;
  localparam logic [COUNT_W-1:0] LEN4 = 3'd4;

  // Classified byte travelling from the front to the back
  typedef struct packed {
    logic [TEXT_W-1:0]  text_byte;
    logic [COUNT_W-1:0] lead_len;
  } entry_t;

endpackage
`default_nettype wire

[rtl/utf8d_front.sv]
// Front end: accepts raw bytes and tags each with its lead class.
// Depends on utf8d_pkg; feeds utf8d_queue.
`default_nettype none
module utf8d_front (
  input  wire logic             s_tvalid,
  output logic                  s_tready,
  input  wire logic [7:0]       s_tdata,   // [7:0] text_byte
  input  wire logic             queue_full,
  output logic                  push,
  output utf8d_pkg::entry_t     push_entry
);
  import utf8d_pkg::*;

  logic [COUNT_W-1:0] lead_len;

  always_comb begin
    case (s_tdata) inside
      [LEAD4_MIN:BYTE_MAX]: lead_len = LEN4;
      [LEAD3_MIN:8'hEF]:    lead_len = LEN3;
      [LEAD2_MIN:8'hDF]:    lead_len = LEN2;
      default:              lead_len = LEN1;
    endcase
  end

  assign s_tready             = !queue_full;
  assign push                 = s_tvalid && !queue_full;
  assign push_entry.text_byte = s_tdata;
  assign push_entry.lead_len  = lead_len;

endmodule
`default_nettype wire

[rtl/utf8d_queue.sv]
// Short FIFO of classified bytes between front and back.
// Depends on utf8d_pkg for the entry type.
`default_nettype none
module utf8d_queue #(
  parameter int DEPTH = 4
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              push,
  input  wire utf8d_pkg::entry_t push_entry,
  input  wire logic              pop,
  output utf8d_pkg::entry_t      pop_entry,
  output logic                   full,
  output logic                   empty
);
  import utf8d_pkg::*;

  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  entry_t            slots [DEPTH];
  logic [IDX_W-1:0]  wr_ptr;
  logic [IDX_W-1:0]  rd_ptr;
  logic [CNT_W-1:0]  count;
  logic              do_push;
  logic              do_pop;

  assign full      = (count == FULL_CNT);
  assign empty     = (count == '0);
  assign do_push   = push && !full;
  assign do_pop    = pop && !empty;
  assign pop_entry = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LAST_IDX) ? '0 : wr_ptr + IDX_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST_IDX) ? '0 : rd_ptr + IDX_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule
`default_nettype wire

[rtl/utf8d_back.sv]
// Back end: assembles code points from classified bytes, holds the result register.
// Depends on utf8d_pkg; drains utf8d_queue.
`default_nettype none
module utf8d_back (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              queue_empty,
  input  wire utf8d_pkg::entry_t pop_entry,
  output logic                   pop,
  output logic                   m_tvalid,
  input  wire logic              m_tready,
  output logic [23:0]            m_tdata    // [20:0] code_point, [23:21] byte_count
);
  import utf8d_pkg::*;

  logic [1:0]         bytes_pending;
  logic [CP_W-1:0]    partial_value;
  logic [COUNT_W-1:0] sequence_length;
  logic [1:0]         bytes_pending_next;
  logic [CP_W-1:0]    partial_value_next;
  logic [COUNT_W-1:0] sequence_length_next;
  logic               emit;
  logic [CP_W-1:0]    code_point;
  logic [COUNT_W-1:0] byte_count;
  logic               out_free;
  logic [7:0]         b;

  assign out_free = !m_tvalid || m_tready;
  assign pop      = !queue_empty && out_free;
  assign b        = pop_entry.text_byte;

  always_comb begin
    bytes_pending_next   = bytes_pending;
    partial_value_next   = partial_value;
    sequence_length_next = sequence_length;
    emit                 = 1'b0;
    code_point           = partial_value;
    byte_count           = sequence_length;
    if (bytes_pending != 2'd0) begin
      // continuation: shift in six payload bits, tag unchecked
      partial_value_next = {partial_value[CP_W-7:0], b[5:0]};
      bytes_pending_next = bytes_pending - 2'd1;
      emit               = (bytes_pending == 2'd1);
      code_point         = partial_value_next;
    end else begin
      case (pop_entry.lead_len)
        LEN4: begin
          partial_value_next   = {{(CP_W-3){1'b0}}, b[2:0]};
          bytes_pending_next   = 2'd3;
          sequence_length_next = LEN4;
        end
        LEN3: begin
          partial_value_next   = {{(CP_W-4){1'b0}}, b[3:0]};
          bytes_pending_next   = 2'd2;
          sequence_length_next = LEN3;
        end
        LEN2: begin
          partial_value_next   = {{(CP_W-5){1'b0}}, b[4:0]};
          bytes_pending_next   = 2'd1;
          sequence_length_next = LEN2;
        end
        default: begin
          partial_value_next   = {{(CP_W-8){1'b0}}, b};
          sequence_length_next = LEN1;
          emit                 = 1'b1;
          code_point           = partial_value_next;
          byte_count           = LEN1;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_pending   <= '0;
      partial_value   <= '0;
      sequence_length <= '0;
      m_tvalid        <= 1'b0;
    end else begin
      if (pop) begin
        bytes_pending   <= bytes_pending_next;
        partial_value   <= partial_value_next;
        sequence_length <= sequence_length_next;
      end
      if (pop && emit) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // Load the result register only when a sequence completes
  always_ff @(posedge clk) begin
    if (pop && emit) begin
      m_tdata <= {byte_count, code_point};
    end
  end

endmodule
`default_nettype wire

[rtl/utf8_to_codepoint_decode.sv]
// UTF-8 to code point decoder, top level.
// Throughput: one byte per cycle unless the output stalls; each byte is one shift-or update
// in the back end. An accepted byte is written into the queue, then popped by the back end,
// which loads the result register; entries waiting ahead of it in the queue are popped first.
// Reset (synchronous, rst high) empties the queue, clears the decode state and drops any result.
// Depends on utf8d_pkg, utf8d_front, utf8d_queue and utf8d_back.
`default_nettype none
module utf8_to_codepoint_decode #(
  parameter int QUEUE_DEPTH = 4
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // [7:0] text_byte
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [23:0]      m_tdata    // [20:0] code_point, [23:21] byte_count
);
  import utf8d_pkg::*;

  entry_t push_entry;
  entry_t pop_entry;
  logic   push;
  logic   pop;
  logic   queue_full;
  logic   queue_empty;

  utf8d_front u_front (
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .queue_full (queue_full),
    .push       (push),
    .push_entry (push_entry)
  );

  utf8d_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .pop_entry  (pop_entry),
    .full       (queue_full),
    .empty      (queue_empty)
  );

  utf8d_back u_back (
    .clk         (clk),
    .rst         (rst),
    .queue_empty (queue_empty),
    .pop_entry   (pop_entry),
    .pop         (pop),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata)
  );

endmodule
`default_nettype wire

[rtl/utf8d_checker.sv]
// Port-level assertions for the UTF-8 decoder, bound to the top level.
// Depends only on the top level's ports.
`default_nettype none
module utf8d_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_tvalid,
  input wire logic        s_tready,
  input wire logic [7:0]  s_tdata,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [23:0] m_tdata
);

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

  a_reset_clears: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result valid right after reset");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[23:21] == 3'd1 || m_tdata[23:21] == 3'd2 ||
                  m_tdata[23:21] == 3'd3 || m_tdata[23:21] == 3'd4))
    else $error("byte count out of range");

  // Code point width follows from the byte count
  a_cp_width: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[23:21] != 3'd1 || m_tdata[20:8] == '0) &&
                 (m_tdata[23:21] != 3'd2 || m_tdata[20:11] == '0) &&
                 (m_tdata[23:21] != 3'd3 || m_tdata[20:16] == '0))
    else $error("code point too wide for byte count");

  // Input side is unused by the properties beyond presence on the bus
  logic unused_in;
  assign unused_in = s_tvalid ^ s_tready ^ (^s_tdata);

endmodule

bind utf8_to_codepoint_decode utf8d_checker u_chk (.*);
`default_nettype wire
